[src/vlrf_pkg.sv]
// Shared types, codes and header layout helpers for the record ring fifo.
// No dependencies; used by the top level and the bench.
package vlrf_pkg;

  localparam int unsigned STORE_BYTES     = 4096;
  localparam int unsigned HEADER_BYTES    = 16;
  localparam int unsigned MAX_FRAME_BYTES = 2048;
  localparam int unsigned TS_OFS          = HEADER_BYTES - 8;
  localparam int unsigned MIN_CAPACITY    = HEADER_BYTES + 1;

  localparam int unsigned CAP_W      = 13;
  localparam int unsigned LIMIT_W    = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // command codes
  localparam logic [2:0] MODE_PUSH_START = 3'd0;
  localparam logic [2:0] MODE_PUSH_BYTE  = 3'd1;
  localparam logic [2:0] MODE_POP_START  = 3'd2;
  localparam logic [2:0] MODE_POP_BYTE   = 3'd3;
  localparam logic [2:0] MODE_FLUSH      = 3'd4;
  localparam logic [2:0] MODE_STATS      = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ARG   = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [2:0] ST_NO_ROOM   = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_BAD_STATE = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 2'd1;

  localparam logic [1:0] TYPE_INVALID = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] frame_length;
    logic [1:0]  frame_type;
    logic [63:0] timestamp;
    logic [7:0]  data_in;
    logic [15:0] reader_room;
  } vlrf_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] out_length;
    logic [1:0]  out_type;
    logic [63:0] out_timestamp;
    logic [7:0]  data_out;
    logic        last_byte;
    logic [12:0] used_count;
    logic [12:0] free_count;
    logic [12:0] high_watermark;
    logic [31:0] pushed_total;
    logic [31:0] popped_total;
    logic [31:0] dropped_total;
  } vlrf_out_t;

  // header byte at offset idx: length le16, type, zeros, timestamp le64 at the end
  function automatic logic [7:0] hdr_byte(logic [3:0] idx, logic [15:0] len,
                                          logic [1:0] typ, logic [63:0] ts);
    logic [7:0] b;
    b = 8'h00;
    if (32'(idx) >= TS_OFS) begin
      b = ts[8*(32'(idx) - TS_OFS) +: 8];
    end else if (idx == 4'd0) begin
      b = len[7:0];
    end else if (idx == 4'd1) begin
      b = len[15:8];
    end else if (idx == 4'd2) begin
      b = {6'b0, typ};
    end
    return b;
  endfunction

endpackage

[src/vlrf_ram.sv]
// Byte-wide single-port ring store with a registered read.
// Depends on nothing; instantiated by the top level.
module vlrf_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/variable_length_record_ring_fifo.sv]
// Record ring fifo top level: command sequencer around the byte ring store.
// Depends on vlrf_pkg and vlrf_ram.
//
// One command is taken when start is high and busy is low; its result is shown on res_o for
// exactly one cycle with res_valid_o high, and the receiver must take it then. Every store
// access goes through the single byte port of the ring memory, one byte per cycle, so that
// port sets the timing: stats, flush, push byte and bad commands go from S_EXEC straight to
// S_FIN, a pop byte passes through S_POPRD, a push start writes the 16 header bytes in S_HDR
// after zeroing up to 16 bytes of a wrap gap in S_PAD, and a pop start reads the header in
// S_RDH, with up to four header reads when padding must be skipped. No clearing pass runs
// after reset. Configuration writes are taken only while busy is low; a write of the capacity
// register empties the queue.
module variable_length_record_ring_fifo #(
  parameter int unsigned StoreBytes = vlrf_pkg::STORE_BYTES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  vlrf_pkg::vlrf_in_t                 in_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [vlrf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [vlrf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                               res_valid_o,
  output vlrf_pkg::vlrf_out_t                res_o
);

  localparam int unsigned AddrW = $clog2(StoreBytes);
  localparam int unsigned CntW  = $clog2(StoreBytes + 1);
  localparam int unsigned CmpW  = 18;
  localparam logic [CmpW-1:0] Hdr18 = CmpW'(vlrf_pkg::HEADER_BYTES);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_EXEC   = 10'b00_0000_0010,
    S_PAD    = 10'b00_0000_0100,
    S_HDR    = 10'b00_0000_1000,
    S_SKIP   = 10'b00_0001_0000,
    S_RDH    = 10'b00_0010_0000,
    S_CHK    = 10'b00_0100_0000,
    S_REPORT = 10'b00_1000_0000,
    S_POPRD  = 10'b01_0000_0000,
    S_FIN    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [vlrf_pkg::CAP_W-1:0]   cap_q, cap_d;
  logic [vlrf_pkg::LIMIT_W-1:0] lim_q, lim_d;
  logic [AddrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  used_q, used_d, peak_q, peak_d;
  logic [31:0]      push_cnt_q, push_cnt_d, pop_cnt_q, pop_cnt_d, drop_cnt_q, drop_cnt_d;
  logic [11:0]      push_rem_q, push_rem_d, wr_len_q, wr_len_d;
  logic [15:0]      pop_rem_q, pop_rem_d, rd_len_q, rd_len_d;
  logic [AddrW-1:0] wr_pos_q, wr_pos_d, wr_start_q, wr_start_d, rd_pos_q, rd_pos_d;
  logic [CntW-1:0]  wr_pad_q, wr_pad_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [1:0]       skip_q, skip_d;
  logic             report_q, report_d;

  vlrf_pkg::vlrf_in_t in_q, in_d;
  logic [2:0]  status_q, status_d;
  logic [11:0] olen_q, olen_d;
  logic [1:0]  otype_q, otype_d;
  logic [63:0] ots_q, ots_d;
  logic [7:0]  odata_q, odata_d;
  logic        last_q, last_d;

  vlrf_pkg::vlrf_out_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  logic [7:0] hdr_q [vlrf_pkg::HEADER_BYTES];
  logic [3:0] hdr_idx;

  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [7:0]       mem_wdata, mem_rdata;

  logic [CntW-1:0]           cap_eff;
  logic [vlrf_pkg::LIMIT_W-1:0] lim_eff;

  // working values
  logic [CmpW-1:0] cap18, used18, rec18, free18, room_h18, room_t18, head18, tail18;
  logic [CmpW-1:0] used_new18;
  logic [15:0]     hlen;
  logic            drop, wrap, bad_hdr;
  logic [4:0]      npad;

  always_comb begin
    if (32'(cap_q) > StoreBytes) begin
      cap_eff = CntW'(StoreBytes);
    end else if (32'(cap_q) < vlrf_pkg::MIN_CAPACITY) begin
      cap_eff = CntW'(vlrf_pkg::MIN_CAPACITY);
    end else begin
      cap_eff = CntW'(cap_q);
    end
    if (lim_q == '0) begin
      lim_eff = vlrf_pkg::LIMIT_W'(1);
    end else if (32'(lim_q) > vlrf_pkg::MAX_FRAME_BYTES) begin
      lim_eff = vlrf_pkg::LIMIT_W'(vlrf_pkg::MAX_FRAME_BYTES);
    end else begin
      lim_eff = lim_q;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign hdr_idx     = 4'(cnt_q - 5'd1);
  assign hlen        = {hdr_q[1], hdr_q[0]};

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = rd_pos_q;
    mem_wdata = 8'h00;
    unique case (state_q)
      S_EXEC: begin
        if (in_q.mode == vlrf_pkg::MODE_PUSH_BYTE && push_rem_q != '0) begin
          mem_we    = 1'b1;
          mem_addr  = wr_pos_q;
          mem_wdata = in_q.data_in;
        end
      end
      S_PAD: begin
        mem_we   = 1'b1;
        mem_addr = head_q + AddrW'(cnt_q);
      end
      S_HDR: begin
        mem_we    = 1'b1;
        mem_addr  = wr_start_q + AddrW'(cnt_q);
        mem_wdata = vlrf_pkg::hdr_byte(cnt_q[3:0], {4'b0, wr_len_q}, in_q.frame_type,
                                       in_q.timestamp);
      end
      S_RDH: mem_addr = tail_q + AddrW'(cnt_q);
      default: ;
    endcase
  end

  vlrf_ram #(
    .Depth(StoreBytes),
    .Width(8)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    cap18      = CmpW'(cap_eff);
    used18     = CmpW'(used_q);
    head18     = CmpW'(head_q);
    tail18     = CmpW'(tail_q);
    free18     = cap18 - used18;
    room_h18   = cap18 - head18;
    room_t18   = cap18 - tail18;
    rec18      = Hdr18 + CmpW'(in_q.frame_length);
    drop       = (rec18 > cap18) || (free18 < rec18);
    wrap       = rec18 > room_h18;
    used_new18 = used18 + CmpW'(wr_pad_q) + Hdr18 + CmpW'(wr_len_q);
    bad_hdr    = (hdr_q[2] > 8'd2) || (hlen > 16'(lim_eff))
              || (Hdr18 + CmpW'(hlen) > room_t18) || (Hdr18 + CmpW'(hlen) > used18);
    npad       = (wr_pad_q >= CntW'(vlrf_pkg::HEADER_BYTES)) ? 5'd16 : 5'(wr_pad_q);
  end

  always_comb begin
    logic [CmpW-1:0] rec_pop, tail_new;
    logic [CmpW-1:0] head_new;
    state_d    = state_q;
    cap_d      = cap_q;
    lim_d      = lim_q;
    head_d     = head_q;
    tail_d     = tail_q;
    used_d     = used_q;
    peak_d     = peak_q;
    push_cnt_d = push_cnt_q;
    pop_cnt_d  = pop_cnt_q;
    drop_cnt_d = drop_cnt_q;
    push_rem_d = push_rem_q;
    pop_rem_d  = pop_rem_q;
    wr_len_d   = wr_len_q;
    rd_len_d   = rd_len_q;
    wr_pos_d   = wr_pos_q;
    wr_start_d = wr_start_q;
    rd_pos_d   = rd_pos_q;
    wr_pad_d   = wr_pad_q;
    cnt_d      = cnt_q;
    skip_d     = skip_q;
    report_d   = report_q;
    in_d       = in_q;
    status_d   = status_q;
    olen_d     = olen_q;
    otype_d    = otype_q;
    ots_d      = ots_q;
    odata_d    = odata_q;
    last_d     = last_q;
    res_d      = res_q;
    res_valid_d = 1'b0;
    rec_pop    = Hdr18 + CmpW'(rd_len_q);
    tail_new   = tail18 + rec_pop;
    head_new   = CmpW'(wr_start_q) + Hdr18 + CmpW'(wr_len_q);

    unique case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) begin
          if (cfg_index_i == vlrf_pkg::CFG_CAPACITY) begin
            cap_d      = cfg_data_i;
            head_d     = '0;
            tail_d     = '0;
            used_d     = '0;
            push_rem_d = '0;
            pop_rem_d  = '0;
          end else if (cfg_index_i == vlrf_pkg::CFG_FRAME_LIMIT) begin
            lim_d = cfg_data_i[vlrf_pkg::LIMIT_W-1:0];
          end
        end
        if (start) begin
          in_d     = in_i;
          status_d = vlrf_pkg::ST_OK;
          olen_d   = '0;
          otype_d  = '0;
          ots_d    = '0;
          odata_d  = '0;
          last_d   = 1'b0;
          state_d  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_FIN;
        if (in_q.mode == vlrf_pkg::MODE_PUSH_START) begin
          if (push_rem_q != '0) begin
            status_d = vlrf_pkg::ST_BAD_STATE;
          end else if (in_q.frame_type == vlrf_pkg::TYPE_INVALID
                       || in_q.frame_length == '0) begin
            status_d = vlrf_pkg::ST_BAD_ARG;
          end else if (in_q.frame_length > 16'(lim_eff)) begin
            status_d = vlrf_pkg::ST_BAD_SIZE;
          end else if (drop || (wrap && free18 < rec18 + room_h18)) begin
            status_d   = vlrf_pkg::ST_NO_ROOM;
            drop_cnt_d = drop_cnt_q + 32'd1;
          end else begin
            wr_len_d   = in_q.frame_length[11:0];
            push_rem_d = in_q.frame_length[11:0];
            wr_pad_d   = wrap ? CntW'(room_h18) : '0;
            wr_start_d = wrap ? '0 : head_q;
            wr_pos_d   = (wrap ? '0 : head_q) + AddrW'(vlrf_pkg::HEADER_BYTES);
            cnt_d      = '0;
            state_d    = wrap ? S_PAD : S_HDR;
          end
        end else if (in_q.mode == vlrf_pkg::MODE_PUSH_BYTE) begin
          if (push_rem_q == '0) begin
            status_d = vlrf_pkg::ST_BAD_STATE;
          end else begin
            wr_pos_d   = wr_pos_q + AddrW'(1);
            push_rem_d = push_rem_q - 12'd1;
            if (push_rem_q == 12'd1) begin
              // commit: gap, header and payload all count as used
              last_d     = 1'b1;
              used_d     = CntW'(used_new18);
              head_d     = (head_new >= cap18) ? '0 : AddrW'(head_new);
              push_cnt_d = push_cnt_q + 32'd1;
              if (used_new18 > CmpW'(peak_q)) begin
                peak_d = CntW'(used_new18);
              end
            end
          end
        end else if (in_q.mode == vlrf_pkg::MODE_POP_START) begin
          if (pop_rem_q != '0) begin
            status_d = vlrf_pkg::ST_BAD_STATE;
          end else begin
            skip_d  = '0;
            state_d = S_SKIP;
          end
        end else if (in_q.mode == vlrf_pkg::MODE_POP_BYTE) begin
          if (pop_rem_q == '0) begin
            status_d = vlrf_pkg::ST_BAD_STATE;
          end else begin
            state_d = S_POPRD;
          end
        end else if (in_q.mode == vlrf_pkg::MODE_FLUSH) begin
          head_d     = '0;
          tail_d     = '0;
          used_d     = '0;
          push_rem_d = '0;
          pop_rem_d  = '0;
        end else if (in_q.mode != vlrf_pkg::MODE_STATS) begin
          status_d = vlrf_pkg::ST_BAD_ARG;
        end
      end

      S_PAD: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q + 5'd1 == npad) begin
          cnt_d   = '0;
          state_d = S_HDR;
        end
      end

      S_HDR: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(vlrf_pkg::HEADER_BYTES - 1)) begin
          state_d = S_FIN;
        end
      end

      S_SKIP: begin
        if (used_q == '0) begin
          status_d = vlrf_pkg::ST_EMPTY;
          state_d  = S_FIN;
        end else if (skip_q == 2'd3) begin
          report_d = 1'b1;
          cnt_d    = '0;
          state_d  = S_RDH;
        end else if (room_t18 < Hdr18) begin
          // gap too short for a header: always padding
          skip_d = skip_q + 2'd1;
          if (room_t18 > used18) begin
            head_d     = '0;
            tail_d     = '0;
            used_d     = '0;
            push_rem_d = '0;
            pop_rem_d  = '0;
          end else begin
            used_d = CntW'(used18 - room_t18);
            tail_d = '0;
          end
        end else begin
          report_d = 1'b0;
          cnt_d    = '0;
          state_d  = S_RDH;
        end
      end

      S_RDH: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(vlrf_pkg::HEADER_BYTES)) begin
          state_d = report_q ? S_REPORT : S_CHK;
        end
      end

      S_CHK: begin
        if (hlen == '0) begin
          skip_d  = skip_q + 2'd1;
          state_d = S_SKIP;
          if (room_t18 > used18) begin
            head_d     = '0;
            tail_d     = '0;
            used_d     = '0;
            push_rem_d = '0;
            pop_rem_d  = '0;
          end else begin
            used_d = CntW'(used18 - room_t18);
            tail_d = '0;
          end
        end else if (bad_hdr) begin
          // corrupt header: drop everything
          head_d     = '0;
          tail_d     = '0;
          used_d     = '0;
          push_rem_d = '0;
          pop_rem_d  = '0;
          status_d   = vlrf_pkg::ST_EMPTY;
          state_d    = S_FIN;
        end else begin
          state_d = S_REPORT;
        end
      end

      S_REPORT: begin
        olen_d  = hlen[11:0];
        otype_d = hdr_q[2][1:0];
        ots_d   = {hdr_q[15], hdr_q[14], hdr_q[13], hdr_q[12],
                   hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]};
        if (in_q.reader_room < hlen) begin
          status_d = vlrf_pkg::ST_BAD_SIZE;
        end else begin
          rd_len_d  = hlen;
          pop_rem_d = hlen;
          rd_pos_d  = tail_q + AddrW'(vlrf_pkg::HEADER_BYTES);
        end
        state_d = S_FIN;
      end

      S_POPRD: begin
        odata_d   = mem_rdata;
        rd_pos_d  = rd_pos_q + AddrW'(1);
        pop_rem_d = pop_rem_q - 16'd1;
        if (pop_rem_q == 16'd1) begin
          last_d    = 1'b1;
          tail_d    = (tail_new >= cap18) ? '0 : AddrW'(tail_new);
          used_d    = (rec_pop > used18) ? '0 : CntW'(used18 - rec_pop);
          pop_cnt_d = pop_cnt_q + 32'd1;
        end
        state_d = S_FIN;
      end

      S_FIN: begin
        res_valid_d          = 1'b1;
        res_d.status         = status_q;
        res_d.out_length     = olen_q;
        res_d.out_type       = otype_q;
        res_d.out_timestamp  = ots_q;
        res_d.data_out       = odata_q;
        res_d.last_byte      = last_q;
        res_d.used_count     = 13'(used_q);
        res_d.free_count     = 13'(cap_eff - used_q);
        res_d.high_watermark = 13'(peak_q);
        res_d.pushed_total   = push_cnt_q;
        res_d.popped_total   = pop_cnt_q;
        res_d.dropped_total  = drop_cnt_q;
        state_d              = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= vlrf_pkg::CAP_W'(vlrf_pkg::STORE_BYTES);
      lim_q       <= vlrf_pkg::LIMIT_W'(vlrf_pkg::MAX_FRAME_BYTES);
      head_q      <= '0;
      tail_q      <= '0;
      used_q      <= '0;
      peak_q      <= '0;
      push_cnt_q  <= '0;
      pop_cnt_q   <= '0;
      drop_cnt_q  <= '0;
      push_rem_q  <= '0;
      pop_rem_q   <= '0;
      cnt_q       <= '0;
      skip_q      <= '0;
      report_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      lim_q       <= lim_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      used_q      <= used_d;
      peak_q      <= peak_d;
      push_cnt_q  <= push_cnt_d;
      pop_cnt_q   <= pop_cnt_d;
      drop_cnt_q  <= drop_cnt_d;
      push_rem_q  <= push_rem_d;
      pop_rem_q   <= pop_rem_d;
      cnt_q       <= cnt_d;
      skip_q      <= skip_d;
      report_q    <= report_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q       <= in_d;
    status_q   <= status_d;
    olen_q     <= olen_d;
    otype_q    <= otype_d;
    ots_q      <= ots_d;
    odata_q    <= odata_d;
    last_q     <= last_d;
    wr_len_q   <= wr_len_d;
    rd_len_q   <= rd_len_d;
    wr_pos_q   <= wr_pos_d;
    wr_start_q <= wr_start_d;
    rd_pos_q   <= rd_pos_d;
    wr_pad_q   <= wr_pad_d;
    res_q      <= res_d;
    // header bytes come through the registered read and are stored while the next read is issued
    if (state_q == S_RDH && cnt_q != '0) begin
      hdr_q[hdr_idx] <= mem_rdata;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[bench/variable_length_record_ring_fifo_test.sv]
// Self-checking bench for the record ring fifo: driver, monitor and byte-level ring predictor.
// Depends on vlrf_pkg and the variable_length_record_ring_fifo top level.
module variable_length_record_ring_fifo_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vlrf_pkg::*;

  typedef enum logic [1:0] {K_CMD, K_CFG, K_DRAIN} job_kind_e;
  typedef struct {
    job_kind_e                kind;
    vlrf_in_t                 cmd;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    val;
    int unsigned              gap;
  } job_t;

  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned STALL_LIMIT   = 2000;

  logic clk_i, rst_ni, start, busy, cfg_valid_i, cfg_ready_o, res_valid_o;
  vlrf_in_t in_i;
  vlrf_out_t res_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  job_t      pending_jobs[$];
  vlrf_out_t expected_results[$];
  int        n_fail;
  int        idle_cycles;
  logic      accepted_any;

  variable_length_record_ring_fifo u_top (
    .clk_i, .rst_ni, .start, .busy, .in_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .res_valid_o, .res_o
  );

  // ring predictor state
  logic [7:0]  ring_img[STORE_BYTES];
  int unsigned cap_reg, limit_reg, head, tail, used, peak;
  logic [31:0] n_push, n_pop, n_drop;
  int unsigned push_left, pop_left, wr_at, wr_base, wr_len, wr_pad, rd_at, rd_len;

  function automatic int unsigned cap_now();
    if (cap_reg < MIN_CAPACITY) return MIN_CAPACITY;
    if (cap_reg > STORE_BYTES) return STORE_BYTES;
    return cap_reg;
  endfunction

  function automatic int unsigned limit_now();
    if (limit_reg < 1) return 1;
    if (limit_reg > MAX_FRAME_BYTES) return MAX_FRAME_BYTES;
    return limit_reg;
  endfunction

  function automatic logic [7:0] rd(int unsigned a);
    return ring_img[a % STORE_BYTES];
  endfunction

  function automatic void wr(int unsigned a, logic [7:0] v);
    ring_img[a % STORE_BYTES] = v;
  endfunction

  function automatic void empty_ring();
    head = 0; tail = 0; used = 0; push_left = 0; pop_left = 0;
  endfunction

  function automatic vlrf_out_t predict(vlrf_in_t c);
    vlrf_out_t   r;
    int unsigned capv, len, rec, freeb, room, pad, base, i, k, typ;
    logic        drop, done;
    capv = cap_now();
    r = '0;
    case (c.mode)
      MODE_PUSH_START: begin
        len = c.frame_length;
        if (push_left != 0) r.status = ST_BAD_STATE;
        else if (c.frame_type == TYPE_INVALID || len == 0) r.status = ST_BAD_ARG;
        else if (len > limit_now()) r.status = ST_BAD_SIZE;
        else begin
          rec = HEADER_BYTES + len;
          freeb = capv - used;
          room = capv - head;
          pad = 0;
          base = head;
          drop = rec > capv || freeb < rec;
          if (!drop && rec > room) begin
            if (freeb < rec + room) drop = 1'b1;
            else begin
              pad = room;
              base = 0;
            end
          end
          if (drop) begin
            n_drop++;
            r.status = ST_NO_ROOM;
          end else begin
            for (i = 0; i < pad && i < HEADER_BYTES; i++) wr(head + i, 8'h00);
            for (i = 0; i < HEADER_BYTES; i++) wr(base + i, 8'h00);
            wr(base, len[7:0]);
            wr(base + 1, len[15:8]);
            wr(base + 2, {6'b0, c.frame_type});
            for (i = 0; i < 8; i++) wr(base + TS_OFS + i, c.timestamp[8*i +: 8]);
            wr_base = base; wr_pad = pad; wr_len = len;
            wr_at = base + HEADER_BYTES;
            push_left = len;
          end
        end
      end
      MODE_PUSH_BYTE: begin
        if (push_left == 0) r.status = ST_BAD_STATE;
        else begin
          wr(wr_at, c.data_in);
          wr_at++;
          push_left--;
          if (push_left == 0) begin
            r.last_byte = 1'b1;
            used += wr_pad + HEADER_BYTES + wr_len;
            head = wr_base + HEADER_BYTES + wr_len;
            if (head >= capv) head = 0;
            n_push++;
            if (used > peak) peak = used;
          end
        end
      end
      MODE_POP_START: begin
        if (pop_left != 0) r.status = ST_BAD_STATE;
        else begin
          // walk over padding at the tail, flush on a corrupt header
          done = 1'b0;
          for (k = 0; k < 3 && used > 0 && !done; k++) begin
            room = capv - tail;
            if (room < HEADER_BYTES || (rd(tail) | rd(tail + 1)) == 0) begin
              if (room > used) begin
                empty_ring();
                done = 1'b1;
              end else begin
                used -= room;
                tail = 0;
              end
            end else begin
              len = {rd(tail + 1), rd(tail)};
              typ = rd(tail + 2);
              rec = HEADER_BYTES + len;
              if (typ > 2 || len > limit_now() || rec > room || rec > used) empty_ring();
              done = 1'b1;
            end
          end
          if (used == 0) r.status = ST_EMPTY;
          else begin
            len = {rd(tail + 1), rd(tail)};
            r.out_length = len[11:0];
            r.out_type = rd(tail + 2) & 8'h03;
            for (i = 0; i < 8; i++) r.out_timestamp[8*i +: 8] = rd(tail + TS_OFS + i);
            if (c.reader_room < len) r.status = ST_BAD_SIZE;
            else begin
              rd_len = len;
              rd_at = tail + HEADER_BYTES;
              pop_left = len;
            end
          end
        end
      end
      MODE_POP_BYTE: begin
        if (pop_left == 0) r.status = ST_BAD_STATE;
        else begin
          r.data_out = rd(rd_at);
          rd_at++;
          pop_left--;
          if (pop_left == 0) begin
            rec = HEADER_BYTES + rd_len;
            r.last_byte = 1'b1;
            tail += rec;
            if (tail >= capv) tail = 0;
            used = rec > used ? 0 : used - rec;
            n_pop++;
          end
        end
      end
      MODE_FLUSH: empty_ring();
      MODE_STATS: ;
      default: r.status = ST_BAD_ARG;
    endcase
    r.used_count = used;
    r.free_count = capv - used;
    r.high_watermark = peak;
    r.pushed_total = n_push;
    r.popped_total = n_pop;
    r.dropped_total = n_drop;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // driver: one command or register write per transaction
  job_t        cur;
  logic        have_job;
  int unsigned wait_left;

  always @(posedge clk_i or negedge rst_ni) begin
    logic go_cmd, go_cfg;
    if (!rst_ni) begin
      start <= 1'b0;
      in_i <= '0;
      cfg_valid_i <= 1'b0;
      cfg_index_i <= '0;
      cfg_data_i <= '0;
      have_job = 1'b0;
      wait_left = 0;
      accepted_any = 1'b0;
    end else begin
      accepted_any = 1'b0;
      if (start && !busy) begin
        expected_results.push_back(predict(in_i));
        accepted_any = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_CAPACITY) begin
          cap_reg = cfg_data_i;
          empty_ring();
        end else if (cfg_index_i == CFG_FRAME_LIMIT) begin
          limit_reg = cfg_data_i & 13'h0FFF;
        end
        accepted_any = 1'b1;
      end
      if (!(start && busy) && !(cfg_valid_i && !cfg_ready_o)) begin
        go_cmd = 1'b0;
        go_cfg = 1'b0;
        if (!have_job && pending_jobs.size() != 0) begin
          cur = pending_jobs.pop_front();
          have_job = 1'b1;
          wait_left = cur.gap;
        end
        if (have_job) begin
          if (cur.kind == K_CMD) begin
            if (wait_left > 0) wait_left--;
            else begin
              go_cmd = 1'b1;
              in_i <= cur.cmd;
              have_job = 1'b0;
            end
          end else if (expected_results.size() == 0) begin
            // idle block: let a trailing command settle first
            if (wait_left > 0) wait_left--;
            else begin
              if (cur.kind == K_CFG) begin
                go_cfg = 1'b1;
                cfg_index_i <= cur.idx;
                cfg_data_i <= cur.val;
              end
              have_job = 1'b0;
            end
          end
        end
        start <= go_cmd;
        cfg_valid_i <= go_cfg;
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  // monitor: results must come in command order
  always @(posedge clk_i) begin
    vlrf_out_t want;
    if (rst_ni) begin
      if (res_valid_o || accepted_any) idle_cycles = 0;
      else idle_cycles++;
      if (res_valid_o) begin
        if (expected_results.size() == 0) begin
          $error("result with no command outstanding");
          n_fail++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, res_o.status);
          check_field("out_length", want.out_length, res_o.out_length);
          check_field("out_type", want.out_type, res_o.out_type);
          check_field("out_timestamp", want.out_timestamp, res_o.out_timestamp);
          check_field("data_out", want.data_out, res_o.data_out);
          check_field("last_byte", want.last_byte, res_o.last_byte);
          check_field("used_count", want.used_count, res_o.used_count);
          check_field("free_count", want.free_count, res_o.free_count);
          check_field("high_watermark", want.high_watermark, res_o.high_watermark);
          check_field("pushed_total", want.pushed_total, res_o.pushed_total);
          check_field("popped_total", want.popped_total, res_o.popped_total);
          check_field("dropped_total", want.dropped_total, res_o.dropped_total);
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("variable_length_record_ring_fifo_test NOT OK");
        $finish;
      end
    end
  end

  // stimulus building
  int unsigned gap_max;
  int unsigned rec_lens[$];

  function automatic int unsigned pick_gap();
    return gap_max == 0 ? 0 : $urandom_range(gap_max, 0);
  endfunction

  function automatic void add_cmd(logic [2:0] mode, logic [15:0] len, logic [1:0] typ,
                                  logic [7:0] data, logic [15:0] room);
    job_t j;
    j.kind = K_CMD;
    j.cmd.mode = mode;
    j.cmd.frame_length = len;
    j.cmd.frame_type = typ;
    j.cmd.timestamp = {$urandom(), $urandom()};
    j.cmd.data_in = data;
    j.cmd.reader_room = room;
    j.idx = '0;
    j.val = '0;
    j.gap = pick_gap();
    pending_jobs.push_back(j);
  endfunction

  function automatic void add_wait(job_kind_e kind, logic [CFG_IDX_W-1:0] idx,
                                   logic [CFG_DATA_W-1:0] val);
    job_t j;
    j.kind = kind;
    j.cmd = '0;
    j.idx = idx;
    j.val = val;
    j.gap = SETTLE_CYCLES;
    pending_jobs.push_back(j);
  endfunction

  function automatic void push_record(int unsigned len);
    int unsigned i;
    add_cmd(MODE_PUSH_START, len, $urandom_range(2, 0), 8'h00, 16'h0000);
    for (i = 0; i < len; i++) add_cmd(MODE_PUSH_BYTE, 16'h0000, 2'd0, $urandom(), 16'h0000);
    rec_lens.push_back(len);
  endfunction

  function automatic void pop_record();
    int unsigned len, i;
    if (rec_lens.size() == 0) begin
      add_cmd(MODE_POP_START, $urandom(), $urandom(), $urandom(), $urandom());
      return;
    end
    len = rec_lens.pop_front();
    if ($urandom_range(9, 0) == 0 && len > 0) begin
      // reader too small: record stays at the tail
      add_cmd(MODE_POP_START, 16'h0000, 2'd0, 8'h00, $urandom_range(len - 1, 0));
      rec_lens.push_front(len);
      return;
    end
    add_cmd(MODE_POP_START, 16'h0000, 2'd0, 8'h00, len + $urandom_range(65535 - len, 0));
    for (i = 0; i < len; i++) add_cmd(MODE_POP_BYTE, 16'h0000, 2'd0, $urandom(), 16'h0000);
  endfunction

  initial begin
    int unsigned ph, n, len, small_lim;
    logic [CFG_DATA_W-1:0] caps[6];
    logic [CFG_DATA_W-1:0] lims[6];
    caps = '{13'd4096, 13'd17, 13'd200, 13'd0, 13'd8191, 13'd90};
    lims = '{13'd2048, 13'd1, 13'd64, 13'd4095, 13'd0, 13'd4096};
    n_fail = 0;
    idle_cycles = 0;
    cap_reg = 4096;
    limit_reg = 2048;
    peak = 0;
    n_push = 0; n_pop = 0; n_drop = 0;
    wr_at = 0; wr_base = 0; wr_len = 0; wr_pad = 0; rd_at = 0; rd_len = 0;
    empty_ring();
    foreach (ring_img[i]) ring_img[i] = 8'h00;
    gap_max = 9;

    // directed corner cases at reset settings
    add_cmd(MODE_POP_START, 16'h0000, 2'd0, 8'h00, 16'hFFFF);
    add_cmd(MODE_PUSH_BYTE, 16'h0000, 2'd0, 8'hFF, 16'h0000);
    add_cmd(MODE_POP_BYTE, 16'h0000, 2'd0, 8'h00, 16'h0000);
    add_cmd(MODE_PUSH_START, 16'd0, 2'd0, 8'h00, 16'h0000);
    add_cmd(MODE_PUSH_START, 16'd5, TYPE_INVALID, 8'h00, 16'h0000);
    add_cmd(MODE_PUSH_START, 16'hFFFF, 2'd1, 8'h00, 16'h0000);
    add_cmd(MODE_PUSH_START, 16'd2049, 2'd2, 8'h00, 16'h0000);
    add_cmd(3'd6, 16'h0000, 2'd0, 8'h00, 16'h0000);
    add_cmd(3'd7, 16'hFFFF, 2'd3, 8'hFF, 16'hFFFF);
    add_cmd(MODE_STATS, 16'h0000, 2'd0, 8'h00, 16'h0000);
    add_cmd(MODE_PUSH_START, 16'd3, 2'd0, 8'h00, 16'h0000);
    add_cmd(MODE_PUSH_START, 16'd3, 2'd0, 8'h00, 16'h0000);
    add_cmd(MODE_PUSH_BYTE, 16'h0000, 2'd0, 8'hA5, 16'h0000);
    add_cmd(MODE_FLUSH, 16'h0000, 2'd0, 8'h00, 16'h0000);
    add_cmd(MODE_PUSH_BYTE, 16'h0000, 2'd0, 8'h5A, 16'h0000);
    push_record(2);
    add_cmd(MODE_POP_START, 16'h0000, 2'd0, 8'h00, 16'd1);
    add_cmd(MODE_POP_START, 16'h0000, 2'd0, 8'h00, 16'd2);
    add_cmd(MODE_POP_START, 16'h0000, 2'd0, 8'h00, 16'd2);
    add_cmd(MODE_POP_BYTE, 16'h0000, 2'd0, 8'h00, 16'h0000);
    rec_lens.delete();
    // corrupt header: shrink the frame limit under a stored record
    add_wait(K_DRAIN, '0, '0);
    push_record(40);
    add_wait(K_CFG, CFG_FRAME_LIMIT, 13'd8);
    add_cmd(MODE_POP_START, 16'h0000, 2'd0, 8'h00, 16'hFFFF);
    add_wait(K_CFG, CFG_FRAME_LIMIT, 13'd2048);
    rec_lens.delete();
    // largest record, in and out
    push_record(2048);
    pop_record();

    for (ph = 0; ph < 6; ph++) begin
      add_wait(K_CFG, CFG_CAPACITY, caps[ph]);
      add_wait(K_CFG, CFG_FRAME_LIMIT, lims[ph]);
      rec_lens.delete();
      gap_max = (ph % 3 == 1) ? 0 : 9;
      small_lim = lims[ph] == 13'd1 || lims[ph] == 13'd0 ? 1 : 48;
      n = 0;
      while (n < 230) begin
        case ($urandom_range(9, 0))
          0, 1, 2, 3: begin
            len = $urandom_range(small_lim, 1);
            push_record(len);
            n += len + 1;
          end
          4, 5, 6: begin
            pop_record();
            n += 2;
          end
          7: begin
            add_cmd($urandom_range(7, 0), $urandom(), $urandom(), $urandom(), $urandom());
            n++;
          end
          8: begin
            add_cmd(MODE_STATS, 16'h0000, 2'd0, 8'h00, 16'h0000);
            n++;
          end
          default: begin
            // broken sequence: push start without its bytes, later flushed
            add_cmd(MODE_PUSH_START, $urandom_range(small_lim, 1), $urandom_range(2, 0),
                    8'h00, 16'h0000);
            add_cmd(MODE_FLUSH, 16'h0000, 2'd0, 8'h00, 16'h0000);
            rec_lens.delete();
            n += 2;
          end
        endcase
      end
      if (ph == 2) add_wait(K_DRAIN, '0, '0);
    end

    do @(posedge clk_i); while (!rst_ni);
    while (pending_jobs.size() != 0 || have_job || start || cfg_valid_i ||
           expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_fail == 0 && expected_results.size() == 0)
      $display("variable_length_record_ring_fifo_test OK");
    else
      $display("variable_length_record_ring_fifo_test NOT OK");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

endmodule

[sim.f]
src/vlrf_pkg.sv
src/vlrf_ram.sv
src/variable_length_record_ring_fifo.sv
bench/variable_length_record_ring_fifo_test.sv
